>>> sv/chj_pkg.sv
// Shared types, codes and constants of the chained hash-join table.
package chj_pkg;

   // Default table sizes.
   localparam int ENTRIES_DEFAULT = 64;
   localparam int BUCKETS_DEFAULT = 128;

   // Hash finalizer constants.
   localparam logic [31:0] MIX_C1 = 32'h85ebca6b;
   localparam logic [31:0] MIX_C2 = 32'hc2b2ae35;

   // Width of the hash bits that the bucket mask can keep.
   localparam int KEEP_BITS = 7;

   // Reset value of the bucket_bits register.
   localparam logic [2:0] BUCKET_BITS_RESET = 3'd7;

   // Command codes.
   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_BUILD = 2'd1;
   localparam logic [1:0] CMD_PROBE = 2'd2;

   // Result status codes.
   localparam logic [1:0] STATUS_DONE    = 2'd0;
   localparam logic [1:0] STATUS_MATCH   = 2'd1;
   localparam logic [1:0] STATUS_NOMATCH = 2'd2;
   localparam logic [1:0] STATUS_FULL    = 2'd3;

   // One input request.
   typedef struct packed {
      logic [1:0]         cmd;
      logic signed [31:0] key;
      logic [15:0]        probe_row;
   } req_type;

   // One result item.
   typedef struct packed {
      logic [1:0]  status;
      logic [5:0]  build_row;
      logic [15:0] match_probe_row;
      logic        last;
   } rsp_type;

   // Controls of the hash pipeline.
   typedef struct packed {
      logic load;
      logic step;
   } hash_ctl_type;

endpackage

>>> sv/chj_hash.sv
// Two-stage murmur3 finalizer and bucket index selection.
module chj_hash #(
   parameter int BUCKETS = chj_pkg::BUCKETS_DEFAULT,
   localparam int BW = $clog2(BUCKETS)
) (
   input  logic                 clock,
   input  chj_pkg::hash_ctl_type ctl,
   input  logic signed [31:0]   key,
   input  logic [2:0]           bucket_bits,
   output logic [BW-1:0]        bucket
);

   localparam int TAB_SIZE = 2 ** chj_pkg::KEEP_BITS;

   typedef logic [TAB_SIZE-1:0][BW-1:0] bkt_tab_type;

   // Masked hash reduced modulo the bucket count, worked out at elaboration.
   function automatic bkt_tab_type build_tab();
      bkt_tab_type t;
      for (int i = 0; i < TAB_SIZE; i++) begin
         t[i] = BW'(i % BUCKETS);
      end
      return t;
   endfunction

   localparam bkt_tab_type BKT_TAB = build_tab();

   logic [31:0] key_u;
   logic [31:0] x1;
   logic [31:0] x2;
   logic [31:0] h1_in;
   logic [31:0] h1_ff;
   logic [31:0] h2_in;
   logic [31:0] h2_ff;
   logic [chj_pkg::KEEP_BITS-1:0] mask;
   logic [chj_pkg::KEEP_BITS-1:0] masked;

   // First xor-shift and multiply, taken straight from the request.
   always_comb begin
      key_u = key;
      x1 = key_u ^ (key_u >> 16);
      h1_in = x1 * chj_pkg::MIX_C1;
   end

   // Second xor-shift and multiply.
   always_comb begin
      x2 = h1_ff ^ (h1_ff >> 13);
      h2_in = x2 * chj_pkg::MIX_C2;
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         h1_ff <= h1_in;
      end
      if (ctl.step) begin
         h2_ff <= h2_in;
      end
   end

   // Final xor-shift on the low bits, mask and reduce.
   always_comb begin
      mask = chj_pkg::KEEP_BITS'((8'd1 << bucket_bits) - 8'd1);
      masked = (h2_ff[chj_pkg::KEEP_BITS-1:0] ^ h2_ff[16 +: chj_pkg::KEEP_BITS]) & mask;
      bucket = BKT_TAB[masked];
   end

endmodule

>>> sv/chj_store.sv
// Bucket head memory and entry memory, each with one registered read port.
module chj_store #(
   parameter int ENTRIES = chj_pkg::ENTRIES_DEFAULT,
   parameter int BUCKETS = chj_pkg::BUCKETS_DEFAULT,
   localparam int RW = $clog2(ENTRIES),
   localparam int CW = $clog2(ENTRIES + 1),
   localparam int BW = $clog2(BUCKETS)
) (
   input  logic          clock,
   input  logic [BW-1:0] head_rd_addr,
   output logic [CW-1:0] head_q,
   input  logic          head_we,
   input  logic [BW-1:0] head_wr_addr,
   input  logic [CW-1:0] head_wr_data,
   input  logic [RW-1:0] ent_rd_addr,
   output logic [31:0]   ent_q_key,
   output logic [CW-1:0] ent_q_next,
   output logic [BW-1:0] ent_q_tag,
   input  logic          ent_we,
   input  logic [RW-1:0] ent_wr_addr,
   input  logic [31:0]   ent_wr_key,
   input  logic [CW-1:0] ent_wr_next,
   input  logic [BW-1:0] ent_wr_tag
);

   localparam int EW = 32 + CW + BW;

   logic [CW-1:0] head_mem [BUCKETS];
   logic [EW-1:0] ent_mem [ENTRIES];
   logic [CW-1:0] head_rd_ff;
   logic [EW-1:0] ent_rd_ff;

   // Head memory: one write and one read a cycle.
   always_ff @(posedge clock) begin
      if (head_we) begin
         head_mem[head_wr_addr] <= head_wr_data;
      end
      head_rd_ff <= head_mem[head_rd_addr];
   end

   // Entry memory holds key, next link and the bucket the entry went into.
   always_ff @(posedge clock) begin
      if (ent_we) begin
         ent_mem[ent_wr_addr] <= {ent_wr_key, ent_wr_next, ent_wr_tag};
      end
      ent_rd_ff <= ent_mem[ent_rd_addr];
   end

   assign head_q     = head_rd_ff;
   assign ent_q_key  = ent_rd_ff[EW-1 -: 32];
   assign ent_q_next = ent_rd_ff[BW +: CW];
   assign ent_q_tag  = ent_rd_ff[BW-1:0];

endmodule

>>> sv/chained_hash_join_table.sv
// Chained hash-join table: sequencer, result register and configuration register.
//
// Requests arrive on req_valid / req_stall / req_data and results leave on
// rsp_valid / rsp_stall / rsp_data; a transfer happens when valid is high and
// stall is low. csr_valid / csr_ready write bucket_bits; csr_ready is always high.
// One request is in work at a time. An unused command gives nothing. A probe
// that finds m keys gives m match results (last set on the final one),
// otherwise one no-match result. The rate is set by the two registered hash
// multiplies, the head read and the entry read, and then one entry read per
// chain link.
// Each result sits in an output register; a stalled receiver holds the
// sequencer only when it has a further result to deliver.
// Reset (synchronous) empties the table and sets bucket_bits to 7; no
// clearing pass is needed, since a bucket head counts only when it
// points below the entry count at an entry filed under that same bucket.
module chained_hash_join_table #(
   parameter int ENTRIES = chj_pkg::ENTRIES_DEFAULT,
   parameter int BUCKETS = chj_pkg::BUCKETS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  chj_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output chj_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_wdata
);

   localparam int RW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);
   localparam int BW = $clog2(BUCKETS);
   localparam logic [CW-1:0] EMPTY_CODE = CW'(ENTRIES);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DISP = 3'd1;
   localparam logic [2:0] ST_HASH = 3'd2;
   localparam logic [2:0] ST_LOOK = 3'd3;
   localparam logic [2:0] ST_WALK = 3'd4;

   logic [2:0]  state_ff, state_in;
   logic [1:0]  cmd_ff, cmd_in;
   logic [31:0] key_ff, key_in;
   logic [15:0] prow_ff, prow_in;
   logic [CW-1:0] count_ff, count_in;
   logic [BW-1:0] bucket_ff, bucket_in;
   logic [CW-1:0] cur_ff, cur_in;
   logic first_ff, first_in;
   logic pend_valid_ff, pend_valid_in;
   logic [RW-1:0] pend_row_ff, pend_row_in;
   logic rsp_valid_ff, rsp_valid_in;
   chj_pkg::rsp_type rsp_ff, rsp_in;
   logic [2:0] bucket_bits_ff, bucket_bits_in;

   chj_pkg::hash_ctl_type hash_ctl;
   logic [BW-1:0] hash_bucket;

   logic [CW-1:0] head_q;
   logic          head_we;
   logic [RW-1:0] ent_rd_addr;
   logic [31:0]   ent_q_key;
   logic [CW-1:0] ent_q_next;
   logic [BW-1:0] ent_q_tag;
   logic          ent_we;
   logic [CW-1:0] ent_wr_next;

   logic out_free;
   logic emit;
   chj_pkg::rsp_type emit_data;
   logic cur_ok;
   logic hit;
   logic advance;

   chj_hash #(.BUCKETS(BUCKETS)) u_hash (
      .clock       (clock),
      .ctl         (hash_ctl),
      .key         (req_data.key),
      .bucket_bits (bucket_bits_ff),
      .bucket      (hash_bucket)
   );

   chj_store #(.ENTRIES(ENTRIES), .BUCKETS(BUCKETS)) u_store (
      .clock        (clock),
      .head_rd_addr (hash_bucket),
      .head_q       (head_q),
      .head_we      (head_we),
      .head_wr_addr (bucket_ff),
      .head_wr_data (count_ff),
      .ent_rd_addr  (ent_rd_addr),
      .ent_q_key    (ent_q_key),
      .ent_q_next   (ent_q_next),
      .ent_q_tag    (ent_q_tag),
      .ent_we       (ent_we),
      .ent_wr_addr  (count_ff[RW-1:0]),
      .ent_wr_key   (key_ff),
      .ent_wr_next  (ent_wr_next),
      .ent_wr_tag   (bucket_ff)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A link counts when it lies below the entry count; the head link must
   // also point at an entry filed under this bucket since the last clear.
   always_comb begin
      cur_ok = 1'b0;
      if (cur_ff < count_ff) begin
         if (!first_ff || (ent_q_tag == bucket_ff)) begin
            cur_ok = 1'b1;
         end
      end
      hit = cur_ok && (ent_q_key == key_ff);
      if (cur_ok) begin
         ent_wr_next = cur_ff;
      end else begin
         ent_wr_next = EMPTY_CODE;
      end
   end

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      prow_in       = prow_ff;
      count_in      = count_ff;
      bucket_in     = bucket_ff;
      cur_in        = cur_ff;
      first_in      = first_ff;
      pend_valid_in = pend_valid_ff;
      pend_row_in   = pend_row_ff;
      hash_ctl      = '0;
      head_we       = 1'b0;
      ent_we        = 1'b0;
      ent_rd_addr   = cur_ff[RW-1:0];
      emit          = 1'b0;
      emit_data     = '0;
      advance       = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in        = req_data.cmd;
               key_in        = req_data.key;
               prow_in       = req_data.probe_row;
               hash_ctl.load = 1'b1;
               state_in      = ST_DISP;
            end
         end
         ST_DISP: begin
            hash_ctl.step = 1'b1;
            case (cmd_ff)
               chj_pkg::CMD_CLEAR: begin
                  if (out_free) begin
                     emit = 1'b1;
                     emit_data.status = chj_pkg::STATUS_DONE;
                     emit_data.last = 1'b1;
                     count_in = '0;
                     state_in = ST_IDLE;
                  end
               end
               chj_pkg::CMD_BUILD: begin
                  if (count_ff == EMPTY_CODE) begin
                     if (out_free) begin
                        emit = 1'b1;
                        emit_data.status = chj_pkg::STATUS_FULL;
                        emit_data.last = 1'b1;
                        state_in = ST_IDLE;
                     end
                  end else begin
                     state_in = ST_HASH;
                  end
               end
               chj_pkg::CMD_PROBE: begin
                  state_in = ST_HASH;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_HASH: begin
            // The head read of this bucket is issued at this edge.
            bucket_in = hash_bucket;
            state_in  = ST_LOOK;
         end
         ST_LOOK: begin
            ent_rd_addr   = head_q[RW-1:0];
            cur_in        = head_q;
            first_in      = 1'b1;
            pend_valid_in = 1'b0;
            state_in      = ST_WALK;
         end
         ST_WALK: begin
            if (cmd_ff == chj_pkg::CMD_BUILD) begin
               // Push the new entry at the head of its chain.
               if (out_free) begin
                  emit = 1'b1;
                  emit_data.status = chj_pkg::STATUS_DONE;
                  emit_data.build_row = 6'(count_ff);
                  emit_data.last = 1'b1;
                  head_we  = 1'b1;
                  ent_we   = 1'b1;
                  count_in = count_ff + 1'b1;
                  state_in = ST_IDLE;
               end
            end else if (!cur_ok) begin
               // End of chain: flush the held match as last, or report no match.
               if (out_free) begin
                  emit = 1'b1;
                  emit_data.last = 1'b1;
                  emit_data.match_probe_row = prow_ff;
                  if (pend_valid_ff) begin
                     emit_data.status = chj_pkg::STATUS_MATCH;
                     emit_data.build_row = 6'(pend_row_ff);
                  end else begin
                     emit_data.status = chj_pkg::STATUS_NOMATCH;
                  end
                  state_in = ST_IDLE;
               end
            end else if (hit && pend_valid_ff) begin
               // A further match: the held one is not the last.
               if (out_free) begin
                  emit = 1'b1;
                  emit_data.status = chj_pkg::STATUS_MATCH;
                  emit_data.build_row = 6'(pend_row_ff);
                  emit_data.match_probe_row = prow_ff;
                  pend_row_in = cur_ff[RW-1:0];
                  advance = 1'b1;
               end
            end else begin
               if (hit) begin
                  pend_valid_in = 1'b1;
                  pend_row_in   = cur_ff[RW-1:0];
               end
               advance = 1'b1;
            end
            if (advance) begin
               cur_in      = ent_q_next;
               ent_rd_addr = ent_q_next[RW-1:0];
               first_in    = 1'b0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result register and configuration register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in = rsp_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_in = emit_data;
      end
      bucket_bits_in = bucket_bits_ff;
      if (csr_valid && csr_ready) begin
         bucket_bits_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         count_ff       <= '0;
         pend_valid_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         bucket_bits_ff <= chj_pkg::BUCKET_BITS_RESET;
      end else begin
         state_ff       <= state_in;
         count_ff       <= count_in;
         pend_valid_ff  <= pend_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         bucket_bits_ff <= bucket_bits_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      key_ff      <= key_in;
      prow_ff     <= prow_in;
      bucket_ff   <= bucket_in;
      cur_ff      <= cur_in;
      first_ff    <= first_in;
      pend_row_ff <= pend_row_in;
      rsp_ff      <= rsp_in;
   end

endmodule
